// ----- hw/rtl/itoa_pkg.sv -----
`default_nettype none

package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 32;

    localparam int BASE_W    = 6;
    localparam int CHAR_W    = 7;
    localparam int DIGIT_W   = 5;

    localparam logic [BASE_W-1:0] MIN_BASE   = 6'd2;
    localparam logic [BASE_W-1:0] MAX_BASE   = 6'd32;
    localparam logic [BASE_W-1:0] DECIMAL    = 6'd10;
    localparam logic [BASE_W-1:0] RESET_BASE = 6'd10;

    localparam logic [CHAR_W-1:0] DIGIT_BASE  = 7'd48;
    localparam logic [CHAR_W-1:0] LETTER_BASE = 7'd65;
    localparam logic [CHAR_W-1:0] MINUS_CHAR  = 7'd45;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {2'b00, d};
        if (dx >= {1'b0, DECIMAL})
        begin
            return LETTER_BASE + dx - {1'b0, DECIMAL};
        end
        return DIGIT_BASE + dx;
    endfunction

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        if (b < MIN_BASE)
        begin
            return MIN_BASE;
        end
        if (b > MAX_BASE)
        begin
            return MAX_BASE;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/itoa_in_if.sv -----
`default_nettype none

interface itoa_in_if #(
    parameter int VALUE_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/itoa_out_if.sv -----
`default_nettype none

interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] digit_char;
    logic       last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/itoa_divider.sv -----
`default_nettype none

module itoa_divider
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [BASE_W-1:0]      divisor,
    output logic                        done,
    output logic [VALUE_WIDTH-1:0]      quotient,
    output logic [BASE_W-1:0]           remainder
);

    localparam int CW = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [BASE_W-1:0]      rem_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [BASE_W:0]        trial;
    logic                   ge;
    logic [BASE_W:0]        diff;

    assign trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(VALUE_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[VALUE_WIDTH-2:0], ge};
            rem_reg <= ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/integer_to_ascii_any_base_core.sv -----
// Digits: a zero value bypasses the divider; otherwise each digit is set by the
// bit-serial divider that yields one quotient bit per cycle.
// Output: per character, a registered digit store read, then a hand off held until ready.
// Items are taken one at a time; a new value is accepted only once the sequencer is idle.
// Reset: base returns to 10, sequencer idles; the digit store is not cleared.
`default_nettype none

module integer_to_ascii_any_base_core
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              number_base_we,
    input  wire logic [BASE_W-1:0] number_base,
    itoa_in_if.sink                din,
    itoa_out_if.source             dout
);

    localparam int CNTW = $clog2(MAX_DIGITS + 1);
    localparam int PW   = $clog2(MAX_DIGITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_START,
        S_DIV_WAIT,
        S_SIGN,
        S_LOAD,
        S_SHOW
    } state_t;

    state_t                 state_reg, state_next;
    logic [BASE_W-1:0]      base_reg;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic [PW-1:0]          ptr_reg, ptr_next;

    logic [CHAR_W-1:0]      store [MAX_DIGITS];
    logic [CHAR_W-1:0]      rd_data_reg;
    logic                   wr_en;
    logic [PW-1:0]          wr_addr;
    logic [CHAR_W-1:0]      wr_data;

    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [BASE_W-1:0]      div_rem;
    logic [CNTW-1:0]        cnt_inc;
    logic [VALUE_WIDTH-1:0] in_mag;

    itoa_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (base_reg),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    assign cnt_inc = cnt_reg + 1'b1;
    assign in_mag  = din.value[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - VALUE_WIDTH'(din.value))
                                              : VALUE_WIDTH'(din.value);

    assign din.ready       = (state_reg == S_IDLE);
    assign dout.valid      = (state_reg == S_SHOW);
    assign dout.digit_char = rd_data_reg;
    assign dout.last       = (ptr_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        wr_en      = 1'b0;
        wr_addr    = cnt_reg[PW-1:0];
        wr_data    = DIGIT_BASE;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (din.valid)
                begin
                    neg_next   = din.value[VALUE_WIDTH-1];
                    mag_next   = in_mag;
                    cnt_next   = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (mag_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_data    = DIGIT_BASE;
                    cnt_next   = cnt_inc;
                    state_next = S_SIGN;
                end
                else
                begin
                    state_next = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    wr_en    = 1'b1;
                    wr_data  = digit_to_char(div_rem[DIGIT_W-1:0]);
                    cnt_next = cnt_inc;
                    mag_next = div_quo;
                    if (div_quo == '0 || cnt_inc == CNTW'(MAX_DIGITS))
                    begin
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        state_next = S_DIV_START;
                    end
                end
            end
            S_SIGN:
            begin
                if (neg_reg && base_reg == DECIMAL && cnt_reg < CNTW'(MAX_DIGITS))
                begin
                    wr_en    = 1'b1;
                    wr_data  = MINUS_CHAR;
                    cnt_next = cnt_inc;
                    ptr_next = cnt_reg[PW-1:0];
                end
                else
                begin
                    ptr_next = PW'(cnt_reg - 1'b1);
                end
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (dout.ready)
                begin
                    if (ptr_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            base_reg  <= RESET_BASE;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
            if (number_base_we)
            begin
                base_reg <= clamp_base(number_base);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wr_addr] <= wr_data;
        end
        rd_data_reg <= store[ptr_reg];
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(din.ready && dout.valid))
        else $error("input ready while a character is offered");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> !din.ready)
        else $error("ready did not drop after an accepted item");

    a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
        (base_reg >= MIN_BASE) && (base_reg <= MAX_BASE))
        else $error("base register out of range");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.ready && dout.last) |=> (!dout.valid && din.ready))
        else $error("string did not end after last character");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(MAX_DIGITS))
        else $error("digit count past store depth");

endmodule

`default_nettype wire

// ----- tb/integer_to_ascii_any_base_core_tb.sv -----
`timescale 1ns / 1ps

module integer_to_ascii_any_base_core_tb;
    import itoa_pkg::*;

    localparam int VW           = VALUE_WIDTH_DEF;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int CFG_SETTLE   = 8;
    localparam int END_SETTLE   = VW + 8;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 45;

    typedef enum bit {ROW_DATA, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [BASE_W-1:0]     base_wr;
        logic signed [VW-1:0]  value;
    } dir_row_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_exp_t;

    logic clk;
    logic rst_n;
    logic base_we;
    logic [BASE_W-1:0] base_wr_data;

    itoa_in_if #(.VALUE_WIDTH(VW)) din_if ();
    itoa_out_if dout_if ();

    integer_to_ascii_any_base_core #(
        .VALUE_WIDTH(VW),
        .MAX_DIGITS (MAX_DIGITS_DEF)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .number_base_we(base_we),
        .number_base   (base_wr_data),
        .din           (din_if),
        .dout          (dout_if)
    );

    char_exp_t         pending_chars [$];
    dir_row_t          dir_rows [$];
    string             dir_text [$];
    logic [BASE_W-1:0] model_base;
    bit                src_steady;
    bit                sink_steady;
    int                mismatches;
    int                n_values;
    int                n_chars;
    int                n_base_writes;
    int                cycle_cnt;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 80);
    endfunction

    // magnitude digits, least significant first, then reversed into the queue
    task automatic push_digits(input logic signed [VW-1:0] v);
        logic [VW-1:0]     mag;
        logic [VW-1:0]     rem;
        logic [CHAR_W-1:0] rev [$];
        logic              neg;
        neg = v[VW-1];
        mag = neg ? (~v + 1'b1) : v;
        while (mag != 0)
        begin
            rem = mag % {{(VW-BASE_W){1'b0}}, model_base};
            mag = mag / {{(VW-BASE_W){1'b0}}, model_base};
            if (rem >= DECIMAL)
            begin
                rev.push_back(LETTER_BASE + rem[CHAR_W-1:0] - CHAR_W'(DECIMAL));
            end
            else
            begin
                rev.push_back(DIGIT_BASE + rem[CHAR_W-1:0]);
            end
        end
        if (rev.size() == 0)
        begin
            rev.push_back(DIGIT_BASE);
        end
        if (neg && model_base == DECIMAL)
        begin
            rev.push_back(MINUS_CHAR);
        end
        for (int i = rev.size() - 1; i >= 0; i--)
        begin
            pending_chars.push_back(char_exp_t'{ch: rev[i], last: (i == 0)});
        end
    endtask

    task automatic push_text(input string text);
        for (int i = 0; i < text.len(); i++)
        begin
            byte c;
            c = text[i];
            pending_chars.push_back(char_exp_t'{ch: c[CHAR_W-1:0],
                                                last: (i == text.len() - 1)});
        end
    endtask

    // drop valid, wait out every pending character, then let the block settle
    task automatic drain(input int settle);
        @(negedge clk);
        din_if.valid <= 1'b0;
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] b);
        drain(CFG_SETTLE);
        @(negedge clk);
        base_we      <= 1'b1;
        base_wr_data <= b;
        model_base = (b < MIN_BASE) ? MIN_BASE : ((b > MAX_BASE) ? MAX_BASE : b);
        @(negedge clk);
        base_we      <= 1'b0;
        base_wr_data <= BASE_W'($urandom);
        n_base_writes++;
    endtask

    task automatic send_value(input logic signed [VW-1:0] v, input string text);
        int g;
        @(negedge clk);
        din_if.valid <= 1'b1;
        din_if.value <= v;
        forever
        begin
            @(posedge clk);
            if (din_if.ready)
            begin
                break;
            end
        end
        if (text.len() == 0)
        begin
            push_digits(v);
        end
        else
        begin
            push_text(text);
        end
        n_values++;
        g = src_steady ? 0 : pick_gap();
        if (g > 0)
        begin
            @(negedge clk);
            din_if.valid <= 1'b0;
            din_if.value <= $urandom;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    function automatic logic signed [VW-1:0] rand_value();
        logic [63:0]   p;
        logic [VW-1:0] m;
        int            pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            return $urandom;
        end
        if (pick < 55)
        begin
            m = $urandom_range(0, 300);
        end
        else if (pick < 70)
        begin
            p = 64'd1;
            repeat ($urandom_range(0, 31))
            begin
                if (p * model_base < 64'h1_0000_0000)
                begin
                    p = p * model_base;
                end
            end
            m = p[VW-1:0] + $urandom_range(0, 2) - 1;
        end
        else if (pick < 80)
        begin
            case ($urandom_range(0, 5))
                0: return 32'h0000_0000;
                1: return 32'h0000_0001;
                2: return 32'hFFFF_FFFF;
                3: return 32'h7FFF_FFFF;
                4: return 32'h8000_0000;
                default: return 32'h8000_0001;
            endcase
        end
        else
        begin
            m = $urandom >> $urandom_range(0, 31);
        end
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    task automatic add_row(input row_kind_t kind, input logic [BASE_W-1:0] b,
                           input logic signed [VW-1:0] v, input string text);
        dir_rows.push_back(dir_row_t'{kind: kind, base_wr: b, value: v});
        dir_text.push_back(text);
    endtask

    initial
    begin : sink_ready
        int hi;
        int lo;
        @(posedge rst_n);
        forever
        begin
            hi = $urandom_range(1, 16);
            repeat (hi)
            begin
                @(negedge clk);
                dout_if.ready <= 1'b1;
            end
            lo = sink_steady ? 0 : pick_gap();
            repeat (lo)
            begin
                @(negedge clk);
                dout_if.ready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_chars
        char_exp_t e;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            n_chars++;
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected char %0d last %0b with no value pending",
                         $time, dout_if.digit_char, dout_if.last);
            end
            else
            begin
                e = pending_chars.pop_front();
                if (dout_if.digit_char !== e.ch)
                begin
                    mismatches++;
                    $display("%0t: digit_char expected %0d ('%c') actual %0d ('%c')",
                             $time, e.ch, e.ch, dout_if.digit_char, dout_if.digit_char);
                end
                if (dout_if.last !== e.last)
                begin
                    mismatches++;
                    $display("%0t: last expected %0b actual %0b", $time, e.last, dout_if.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d chars pending", $time, pending_chars.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int n_directed;
        rst_n         = 1'b0;
        base_we       = 1'b0;
        base_wr_data  = '0;
        din_if.valid  = 1'b0;
        din_if.value  = '0;
        dout_if.ready = 1'b0;
        model_base    = RESET_BASE;
        src_steady    = 1'b0;
        sink_steady   = 1'b0;
        mismatches    = 0;
        n_values      = 0;
        n_chars       = 0;
        n_base_writes = 0;
        cycle_cnt     = 0;

        add_row(ROW_DATA, '0, 32'sd0,          "0");
        add_row(ROW_DATA, '0, 32'sh7FFF_FFFF,  "2147483647");
        add_row(ROW_DATA, '0, 32'sh8000_0000,  "-2147483648");
        add_row(ROW_DATA, '0, -32'sd1,         "-1");
        add_row(ROW_DATA, '0, 32'sd10,         "10");
        add_row(ROW_CFG,  6'd0, '0, "");
        add_row(ROW_DATA, '0, -32'sd1,         "1");
        add_row(ROW_DATA, '0, 32'sd5,          "101");
        add_row(ROW_DATA, '0, 32'sh8000_0000,  "");
        add_row(ROW_CFG,  6'd1, '0, "");
        add_row(ROW_DATA, '0, 32'sd6,          "110");
        add_row(ROW_CFG,  6'd63, '0, "");
        add_row(ROW_DATA, '0, 32'sh7FFF_FFFF,  "1VVVVVV");
        add_row(ROW_DATA, '0, 32'sd31,         "V");
        add_row(ROW_DATA, '0, 32'sd32,         "10");
        add_row(ROW_DATA, '0, 32'sh8000_0000,  "2000000");
        add_row(ROW_CFG,  6'd33, '0, "");
        add_row(ROW_DATA, '0, -32'sd32,        "10");
        add_row(ROW_CFG,  6'd16, '0, "");
        add_row(ROW_DATA, '0, 32'sd255,        "FF");
        add_row(ROW_DATA, '0, 32'sh8000_0000,  "80000000");
        add_row(ROW_DATA, '0, -32'sd1,         "1");
        add_row(ROW_CFG,  6'd11, '0, "");
        add_row(ROW_DATA, '0, 32'sd10,         "A");
        add_row(ROW_DATA, '0, -32'sd10,        "A");
        add_row(ROW_CFG,  6'd36, '0, "");
        add_row(ROW_DATA, '0, 32'sd1023,       "");
        add_row(ROW_CFG,  6'd10, '0, "");
        add_row(ROW_DATA, '0, 32'sd0,          "0");
        add_row(ROW_DATA, '0, -32'sd7,         "-7");
        add_row(ROW_DATA, '0, 32'sd123456789,  "");

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                write_base(dir_rows[i].base_wr);
            end
            else
            begin
                send_value(dir_rows[i].value, dir_text[i]);
            end
        end
        n_directed = n_values;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: write_base(MIN_BASE);
                1: write_base(MAX_BASE);
                2: write_base(DECIMAL);
                default: write_base(BASE_W'($urandom_range(0, 63)));
            endcase
            src_steady  = (ph == 5);
            sink_steady = (ph == 5) || (ph == 6);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // hold off the sender until the block has emptied
                if (ph == 3 && k == PHASE_ITEMS / 2)
                begin
                    drain(0);
                end
                send_value(rand_value(), "");
            end
        end

        drain(END_SETTLE);

        $display("covered %0d values (%0d directed) over %0d base writes, radix 2 to 32",
                 n_values, n_directed, n_base_writes);
        $display("checked %0d characters, %0d mismatches", n_chars, mismatches);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
